[rtl/face_normal_packer_assert.svh]
// ---------------------------------------------------------------------------
// Face normal packer assertion macros
// Concurrent assertion wrappers used by the output buffer of the block.
// ---------------------------------------------------------------------------
`ifndef FACE_NORMAL_PACKER_ASSERT_SVH
`define FACE_NORMAL_PACKER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define FNP_ASSERT(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FNP_ASSERT_ALWAYS(label, ck, prop, msg) \
  label: assert property (@(posedge ck) prop) else $error(msg);

`else

`define FNP_ASSERT(label, ck, rs, prop, msg)
`define FNP_ASSERT_ALWAYS(label, ck, prop, msg)

`endif

`endif

[rtl/fnp_pkg.sv]
// ---------------------------------------------------------------------------
// Face normal packer package
// Payload types, datapath widths and constants shared by the block.
// ---------------------------------------------------------------------------
package fnp_pkg;

  // Coordinate width and the widths that follow from it.
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;      // edge vector component
  localparam int HALF_W     = COORD_BITS + 1;      // half of a normal magnitude
  localparam int MUL_W      = HALF_W + 1;          // signed multiplier operand
  localparam int PROD_W     = 2 * MUL_W;           // multiplier product
  localparam int MAG_W      = 2 * HALF_W;          // normal component magnitude
  localparam int NRM_W      = MAG_W + 1;           // signed normal component
  localparam int SUM_W      = 2 * MAG_W;           // squared length
  localparam int LEN_W      = MAG_W;               // integer square root
  localparam int REM_W      = LEN_W + 3;           // square root remainder
  localparam int STEP_W     = $clog2(LEN_W);       // iteration counter

  // Code conversion: scale is 2^SCALE_SHIFT - 1.
  localparam int CODE_W      = 10;
  localparam int SCALE_SHIFT = 9;
  localparam int NUM_W       = LEN_W + 1 + SCALE_SHIFT;
  localparam int PACK_W      = 3 * CODE_W;
  localparam logic [CODE_W-1:0] CODE_SCALE = CODE_W'((1 << SCALE_SHIFT) - 1);
  localparam logic [CODE_W-1:0] CODE_MAX   = CODE_W'(2 * ((1 << SCALE_SHIFT) - 1));

  // Each packed word goes out once per vertex of the triangle.
  localparam int COPY_W = 2;
  localparam logic [COPY_W-1:0] NUM_COPIES = COPY_W'(3);
  localparam logic [COPY_W-1:0] LAST_COPY  = COPY_W'(1);

  // One vertex request.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } vertex_t;

  // One normal request.
  typedef struct packed {
    logic [PACK_W-1:0] packed_normal;
    logic              degenerate;
    logic              last_of_triangle;
  } normal_t;

  // Load command from the sequencer into the output buffer.
  typedef struct packed {
    logic              valid;
    logic [PACK_W-1:0] word;
    logic              degenerate;
  } fnp_load_t;

endpackage

[rtl/fnp_out_buf.sv]
// ---------------------------------------------------------------------------
// Face normal packer output buffer
// Holds one packed normal and presents it three times, marking the last.
// ---------------------------------------------------------------------------
`include "face_normal_packer_assert.svh"

module fnp_out_buf
  import fnp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  fnp_load_t load,
  output logic      idle,
  output logic      normal_valid,
  input  logic      normal_ready,
  output normal_t   normal
);

  logic [COPY_W-1:0] left;
  logic [PACK_W-1:0] word;
  logic              degen;

  // Copy counter: filled on load, counted down per accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load.valid) begin
      left <= NUM_COPIES;
    end else if (normal_valid && normal_ready) begin
      left <= left - COPY_W'(1);
    end
  end

  // Payload is captured only on load.
  always_ff @(posedge clk) begin
    if (load.valid) begin
      word  <= load.word;
      degen <= load.degenerate;
    end
  end

  // Output request.
  assign idle                    = (left == '0);
  assign normal_valid            = !idle;
  assign normal.packed_normal    = word;
  assign normal.degenerate       = degen;
  assign normal.last_of_triangle = (left == LAST_COPY);

  // The sequencer only loads an empty buffer.
  `FNP_ASSERT(a_load_into_empty, clk, rst, load.valid |-> idle, "load while copies pending")
  // A load always yields exactly three copies.
  `FNP_ASSERT(a_load_fills, clk, rst, load.valid |=> (left == NUM_COPIES), "load did not fill")
  // Taking the last copy empties the buffer.
  `FNP_ASSERT(a_last_drains, clk, rst, (normal_valid && normal_ready && normal.last_of_triangle) |=> !normal_valid, "copy after last")
  // Reset leaves nothing to send.
  `FNP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !normal_valid, "output valid after reset")

endmodule

[rtl/face_normal_packer.sv]
// ---------------------------------------------------------------------------
// Face normal packer
// Flat triangle normals, packed as three 10-bit codes per vertex.
// ---------------------------------------------------------------------------
// Usage: vertices arrive on the vertex channel (valid/ready), one x, y, z
// triple per request; every three requests form one triangle a, b, c.
// The first two vertices of a triangle are held without a stall. On the
// third, the block computes n = (b-a) x (c-a), len = floor(sqrt(|n|^2)) and
// code_i = floor(511*(n_i+len)/len), and sends the packed word three times
// on the normal channel, the third copy with last_of_triangle set. A zero
// normal gives 511 in every field and sets degenerate.
// Busy phase: the third vertex keeps vertex_ready low while the block
// forms the cross product and the squared length on one shared 18x18
// multiplier, runs 34 square root steps and the three divides on one
// shared subtractor, and hands the word to the output buffer. The first
// copy is valid the cycle after that.
// Stalls: the output buffer holds one word; the next two vertices are
// still taken while it drains, and the next triangle waits at its hand-off
// only if copies are still pending. Reset empties the buffer and restarts
// the vertex count at the first vertex of a triangle.
// ---------------------------------------------------------------------------
module face_normal_packer
  import fnp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    vertex_valid,
  output logic    vertex_ready,
  input  vertex_t vertex,
  output logic    normal_valid,
  input  logic    normal_ready,
  output normal_t normal
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CROSS    = 7'b0000010,
    S_SQUARE   = 7'b0000100,
    S_ROOT     = 7'b0001000,
    S_DIV_LOAD = 7'b0010000,
    S_DIV_STEP = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  localparam logic [1:0] PHASE_ZERO = 2'd0;
  localparam logic [1:0] PHASE_ONE  = 2'd1;
  localparam logic [1:0] PHASE_TWO  = 2'd2;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // Cross product uses the first two parts, squaring all three.
  localparam logic [1:0] PART_HH = 2'd0;
  localparam logic [1:0] PART_HL = 2'd1;
  localparam logic [1:0] PART_LL = 2'd2;

  state_t            state;
  logic [1:0]        phase;
  vertex_t           held_a;
  vertex_t           held_b;
  logic [1:0]        comp;
  logic [1:0]        part;
  logic              half;
  logic [STEP_W-1:0] step;

  logic signed [DIFF_W-1:0] e1_x, e1_y, e1_z;
  logic signed [DIFF_W-1:0] e2_x, e2_y, e2_z;
  logic signed [NRM_W-1:0]  nrm_x, nrm_y, nrm_z, acc;
  logic signed [PROD_W-1:0] prod;
  logic [SUM_W-1:0]         sum;
  logic [REM_W-1:0]         rem;
  logic [LEN_W-1:0]         root;
  logic [NUM_W-1:0]         dvd;
  logic [NUM_W-1:0]         dvs;
  logic [CODE_W-1:0]        quo;
  logic [CODE_W-1:0]        code_x, code_y, code_z;
  logic                     degen;

  logic signed [NRM_W-1:0]  nrm_sel;
  logic [MAG_W-1:0]         mag;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [SUM_W-1:0]         sq_term;
  logic [REM_W-1:0]         rem_sh;
  logic [REM_W-1:0]         trial;
  logic [NUM_W-1:0]         alu_a, alu_b;
  logic [NUM_W:0]           alu_diff;
  logic                     alu_ge;
  logic [NUM_W-1:0]         num_base;
  logic [NUM_W-1:0]         num;
  logic [CODE_W-1:0]        quo_last;
  logic [CODE_W-1:0]        code_new;
  logic                     buf_idle;
  fnp_load_t                load;

  assign vertex_ready = (state == S_IDLE);

  // Normal component picked by the component counter.
  always_comb begin
    unique case (comp)
      COMP_Y:  nrm_sel = nrm_y;
      COMP_Z:  nrm_sel = nrm_z;
      default: nrm_sel = nrm_x;
    endcase
    mag = nrm_sel[NRM_W-1] ? MAG_W'(-nrm_sel) : MAG_W'(nrm_sel);
  end

  // Operands of the shared multiplier.
  always_comb begin
    mul_a = MUL_W'(e1_y);
    mul_b = MUL_W'(e2_z);
    if (state == S_CROSS) begin
      unique case ({comp, part[0]})
        {COMP_X, 1'b1}: begin mul_a = MUL_W'(e1_z); mul_b = MUL_W'(e2_y); end
        {COMP_Y, 1'b0}: begin mul_a = MUL_W'(e1_z); mul_b = MUL_W'(e2_x); end
        {COMP_Y, 1'b1}: begin mul_a = MUL_W'(e1_x); mul_b = MUL_W'(e2_z); end
        {COMP_Z, 1'b0}: begin mul_a = MUL_W'(e1_x); mul_b = MUL_W'(e2_y); end
        {COMP_Z, 1'b1}: begin mul_a = MUL_W'(e1_y); mul_b = MUL_W'(e2_x); end
        default: begin mul_a = MUL_W'(e1_y); mul_b = MUL_W'(e2_z); end
      endcase
    end else begin
      unique case (part)
        PART_HH: begin
          mul_a = signed'({1'b0, mag[MAG_W-1:HALF_W]});
          mul_b = signed'({1'b0, mag[MAG_W-1:HALF_W]});
        end
        PART_HL: begin
          mul_a = signed'({1'b0, mag[MAG_W-1:HALF_W]});
          mul_b = signed'({1'b0, mag[HALF_W-1:0]});
        end
        default: begin
          mul_a = signed'({1'b0, mag[HALF_W-1:0]});
          mul_b = signed'({1'b0, mag[HALF_W-1:0]});
        end
      endcase
    end
  end

  // Partial square placed at its weight in the squared length.
  always_comb begin
    unique case (part)
      PART_HH: sq_term = SUM_W'(prod[2*HALF_W-1:0]) << (2 * HALF_W);
      PART_HL: sq_term = SUM_W'(prod[2*HALF_W-1:0]) << (HALF_W + 1);
      default: sq_term = SUM_W'(prod[2*HALF_W-1:0]);
    endcase
  end

  // Shared subtract and compare unit for the root and divide steps.
  assign rem_sh = {rem[REM_W-3:0], sum[SUM_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});

  always_comb begin
    unique case (state)
      S_ROOT: begin
        alu_a = NUM_W'(rem_sh);
        alu_b = NUM_W'(trial);
      end
      default: begin
        alu_a = dvd;
        alu_b = dvs;
      end
    endcase
    alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    alu_ge   = !alu_diff[NUM_W];
  end

  // Dividend 511 * (n + len), as a shift and a subtract.
  assign num_base = NUM_W'(nrm_sel) + NUM_W'(root);
  assign num      = (num_base << SCALE_SHIFT) - num_base;

  // Final quotient, clamped, with the zero-length case forced to mid scale.
  assign quo_last = {quo[CODE_W-2:0], alu_ge};
  assign code_new = degen ? CODE_SCALE :
                    (quo_last > CODE_MAX) ? CODE_MAX : quo_last;

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PHASE_ZERO;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (vertex_valid) begin
            case (phase)
              PHASE_ONE: begin
                held_b <= vertex;
                phase  <= PHASE_TWO;
              end
              PHASE_TWO: begin
                e1_x  <= DIFF_W'(held_b.pos_x) - DIFF_W'(held_a.pos_x);
                e1_y  <= DIFF_W'(held_b.pos_y) - DIFF_W'(held_a.pos_y);
                e1_z  <= DIFF_W'(held_b.pos_z) - DIFF_W'(held_a.pos_z);
                e2_x  <= DIFF_W'(vertex.pos_x) - DIFF_W'(held_a.pos_x);
                e2_y  <= DIFF_W'(vertex.pos_y) - DIFF_W'(held_a.pos_y);
                e2_z  <= DIFF_W'(vertex.pos_z) - DIFF_W'(held_a.pos_z);
                phase <= PHASE_ZERO;
                comp  <= COMP_X;
                part  <= PART_HH;
                half  <= 1'b0;
                state <= S_CROSS;
              end
              default: begin
                held_a <= vertex;
                phase  <= PHASE_ONE;
              end
            endcase
          end
        end

        // Two products per component: multiply, then combine.
        S_CROSS: begin
          half <= !half;
          if (!half) begin
            prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
          end else if (part == PART_HH) begin
            acc  <= prod[NRM_W-1:0];
            part <= PART_HL;
          end else begin
            unique case (comp)
              COMP_Y:  nrm_y <= acc - prod[NRM_W-1:0];
              COMP_Z:  nrm_z <= acc - prod[NRM_W-1:0];
              default: nrm_x <= acc - prod[NRM_W-1:0];
            endcase
            part <= PART_HH;
            if (comp == COMP_Z) begin
              comp  <= COMP_X;
              sum   <= '0;
              state <= S_SQUARE;
            end else begin
              comp <= comp + 2'd1;
            end
          end
        end

        // Three partial squares per component, accumulated.
        S_SQUARE: begin
          half <= !half;
          if (!half) begin
            prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
          end else begin
            sum <= sum + sq_term;
            if (part == PART_LL) begin
              part <= PART_HH;
              if (comp == COMP_Z) begin
                rem   <= '0;
                root  <= '0;
                step  <= STEP_W'(LEN_W - 1);
                state <= S_ROOT;
              end else begin
                comp <= comp + 2'd1;
              end
            end else begin
              part <= part + 2'd1;
            end
          end
        end

        // One root bit per cycle, two radicand bits shifted in.
        S_ROOT: begin
          sum  <= sum << 2;
          rem  <= alu_ge ? alu_diff[REM_W-1:0] : rem_sh;
          root <= {root[LEN_W-2:0], alu_ge};
          step <= step - STEP_W'(1);
          if (step == '0) begin
            degen <= ({root[LEN_W-2:0], alu_ge} == '0);
            comp  <= COMP_X;
            state <= S_DIV_LOAD;
          end
        end

        S_DIV_LOAD: begin
          dvd   <= num;
          dvs   <= NUM_W'(root) << (CODE_W - 1);
          quo   <= '0;
          step  <= STEP_W'(CODE_W - 1);
          state <= S_DIV_STEP;
        end

        // Restoring division, one quotient bit per cycle.
        S_DIV_STEP: begin
          if (alu_ge) begin
            dvd <= alu_diff[NUM_W-1:0];
          end
          dvs  <= dvs >> 1;
          quo  <= quo_last;
          step <= step - STEP_W'(1);
          if (step == '0) begin
            unique case (comp)
              COMP_Y:  code_y <= code_new;
              COMP_Z:  code_z <= code_new;
              default: code_x <= code_new;
            endcase
            if (comp == COMP_Z) begin
              state <= S_EMIT;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_DIV_LOAD;
            end
          end
        end

        S_EMIT: begin
          if (buf_idle) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hand-off of the finished word to the output buffer.
  assign load.valid      = (state == S_EMIT) && buf_idle;
  assign load.word       = {code_z, code_y, code_x};
  assign load.degenerate = degen;

  fnp_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .idle         (buf_idle),
    .normal_valid (normal_valid),
    .normal_ready (normal_ready),
    .normal       (normal)
  );

endmodule

[sim/tb_face_normal_packer.sv]
// ---------------------------------------------------------------------------
// Face normal packer testbench
// Drives vertex requests through the block and checks every normal request
// against an in-bench predictor of the cross product, integer length and
// 10:10:10 code packing. The run covers directed shapes, random triangles
// under several idle and stall mixes, and a long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_face_normal_packer;
  import fnp_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 4;
  localparam int STALL_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 120;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int REPORT_LIMIT    = 10;
  localparam int TRIS_PER_PHASE  = 6;

  typedef enum int {TRI_SPREAD, TRI_COMPACT, TRI_COLLINEAR} tri_shape_t;

  logic    clk = 1'b0;
  logic    rst;
  logic    vertex_valid;
  logic    vertex_ready;
  vertex_t vertex;
  logic    normal_valid;
  logic    normal_ready;
  normal_t normal;

  // Predictor state: the first two corners of the triangle being collected.
  vertex_t     corner_a;
  vertex_t     corner_b;
  int unsigned corners_held = 0;
  normal_t     normal_expected[$];

  int normal_faults       = 0;
  int quiet_cycles        = 0;
  int sender_idle_pct     = 0;
  int receiver_stall_pct  = 0;
  int hold_off_request    = 0;
  int hold_off_left       = 0;

  face_normal_packer dut (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertex       (vertex),
    .normal_valid (normal_valid),
    .normal_ready (normal_ready),
    .normal       (normal)
  );

  always #CLK_HALF clk = ~clk;

  // Flat normal of triangle a, b, c as the packed code word and zero flag.
  function automatic void face_normal(input vertex_t a, input vertex_t b, input vertex_t c,
                                      output logic [PACK_W-1:0] word, output logic degen);
    longint            e1[3];
    longint            e2[3];
    longint            nrm[3];
    logic [127:0]      mag;
    logic [127:0]      sum_sq;
    logic [63:0]       root;
    logic [63:0]       cand;
    logic [63:0]       num;
    logic [63:0]       quot;
    logic [CODE_W-1:0] code;
    e1[0] = longint'(b.pos_x) - longint'(a.pos_x);
    e1[1] = longint'(b.pos_y) - longint'(a.pos_y);
    e1[2] = longint'(b.pos_z) - longint'(a.pos_z);
    e2[0] = longint'(c.pos_x) - longint'(a.pos_x);
    e2[1] = longint'(c.pos_y) - longint'(a.pos_y);
    e2[2] = longint'(c.pos_z) - longint'(a.pos_z);
    nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
    nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
    nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      mag = 128'((nrm[i] < 0) ? -nrm[i] : nrm[i]);
      sum_sq = sum_sq + mag * mag;
    end
    // The squared length stays below 2^72, so the root fits in 41 bits.
    root = '0;
    for (int k = 40; k >= 0; k--) begin
      cand = root | (64'd1 << k);
      if (128'(cand) * 128'(cand) <= sum_sq) begin
        root = cand;
      end
    end
    degen = (root == 0);
    word = '0;
    for (int i = 0; i < 3; i++) begin
      if (root == 0) begin
        code = CODE_SCALE;
      end else begin
        num  = 64'(nrm[i] + longint'(root)) * 64'(CODE_SCALE);
        quot = num / root;
        if (quot > 64'(CODE_MAX)) begin
          quot = 64'(CODE_MAX);
        end
        code = quot[CODE_W-1:0];
      end
      word[i*CODE_W +: CODE_W] = code;
    end
  endfunction

  // Tracks the corner count and queues three copies on the closing vertex.
  task automatic absorb_vertex(input vertex_t v);
    normal_t           copy;
    logic [PACK_W-1:0] word;
    logic              degen;
    if (corners_held == 0) begin
      corner_a     = v;
      corners_held = 1;
    end else if (corners_held == 1) begin
      corner_b     = v;
      corners_held = 2;
    end else begin
      corners_held = 0;
      face_normal(corner_a, corner_b, v, word, degen);
      for (int k = 0; k < 3; k++) begin
        copy.packed_normal    = word;
        copy.degenerate       = degen;
        copy.last_of_triangle = (k == 2);
        normal_expected.push_back(copy);
      end
    end
  endtask

  // Compares one normal request with the oldest pending one.
  task automatic check_normal(input normal_t got);
    normal_t want;
    if (normal_expected.size() == 0) begin
      normal_faults++;
      if (normal_faults <= REPORT_LIMIT) begin
        $display("ERROR: unexpected normal word=%h degen=%b last=%b",
                 got.packed_normal, got.degenerate, got.last_of_triangle);
      end
    end else begin
      want = normal_expected.pop_front();
      if (got.packed_normal !== want.packed_normal || got.degenerate !== want.degenerate ||
          got.last_of_triangle !== want.last_of_triangle) begin
        normal_faults++;
        if (normal_faults <= REPORT_LIMIT) begin
          $display({"ERROR: normal mismatch: expected word=%h degen=%b last=%b,",
                    " got word=%h degen=%b last=%b"},
                   want.packed_normal, want.degenerate, want.last_of_triangle,
                   got.packed_normal, got.degenerate, got.last_of_triangle);
        end
      end
    end
  endtask

  // Observe both channels at each rising edge; the prediction runs first.
  always @(posedge clk) begin
    if (!rst) begin
      if (vertex_valid && vertex_ready) begin
        absorb_vertex(vertex);
      end
      if (normal_valid && normal_ready) begin
        check_normal(normal);
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no request accepted.
  always @(posedge clk) begin
    if (rst || (vertex_valid && vertex_ready) || (normal_valid && normal_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_off_request != 0) begin
      hold_off_left    = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_off_left != 0) begin
      normal_ready <= 1'b0;
      hold_off_left--;
    end else begin
      normal_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic vertex_t make_vertex(input int x, input int y, input int z);
    vertex_t v;
    v.pos_x = 16'(x);
    v.pos_y = 16'(y);
    v.pos_z = 16'(z);
    return v;
  endfunction

  // A span of zero means the full coordinate range.
  function automatic vertex_t random_vertex(input int span);
    if (span == 0) begin
      return make_vertex($urandom, $urandom, $urandom);
    end
    return make_vertex(int'($urandom_range(2 * span)) - span,
                       int'($urandom_range(2 * span)) - span,
                       int'($urandom_range(2 * span)) - span);
  endfunction

  // Sends one vertex request, with a random idle gap in front of it.
  // Valid is lowered only when a gap is taken, so back-to-back requests
  // keep it high without a second assignment in the same step.
  task automatic send_vertex(input vertex_t v);
    if ($urandom_range(99) < sender_idle_pct) begin
      vertex_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    vertex_valid <= 1'b1;
    vertex       <= v;
    do @(posedge clk); while (!vertex_ready);
  endtask

  task automatic send_triangle(input vertex_t a, input vertex_t b, input vertex_t c);
    send_vertex(a);
    send_vertex(b);
    send_vertex(c);
  endtask

  // Stops offering requests until every pending normal has come back.
  task automatic wait_results_drained();
    vertex_valid <= 1'b0;
    do @(posedge clk); while (normal_expected.size() != 0);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // Mostly full-range triangles, some small ones and some collinear ones.
  task automatic send_random_triangles(input int count);
    tri_shape_t shape;
    vertex_t    a;
    vertex_t    d;
    int         pick;
    int         k;
    for (int t = 0; t < count; t++) begin
      pick  = $urandom_range(99);
      shape = (pick < 60) ? TRI_SPREAD : (pick < 85) ? TRI_COMPACT : TRI_COLLINEAR;
      case (shape)
        TRI_SPREAD: begin
          send_triangle(random_vertex(0), random_vertex(0), random_vertex(0));
        end
        TRI_COMPACT: begin
          send_triangle(random_vertex(40), random_vertex(40), random_vertex(40));
        end
        default: begin
          // Points on one line, duplicates included when the step is zero.
          a = random_vertex(8000);
          d = random_vertex(4000);
          k = int'($urandom_range(4)) - 2;
          send_triangle(a,
                        make_vertex(a.pos_x + d.pos_x, a.pos_y + d.pos_y, a.pos_z + d.pos_z),
                        make_vertex(a.pos_x + k * d.pos_x, a.pos_y + k * d.pos_y,
                                    a.pos_z + k * d.pos_z));
        end
      endcase
    end
  endtask

  // Axis normals of both signs, zero normals, extreme corners and bit patterns.
  task automatic test_directed_shapes();
    set_idling(0, 0);
    send_triangle(make_vertex(0, 0, 0), make_vertex(1, 0, 0), make_vertex(0, 1, 0));
    send_triangle(make_vertex(0, 0, 0), make_vertex(0, 1, 0), make_vertex(1, 0, 0));
    send_triangle(make_vertex(5, 5, 5), make_vertex(5, 5, 5), make_vertex(5, 5, 5));
    send_triangle(make_vertex(1, 2, 3), make_vertex(3, 6, 9), make_vertex(-1, -2, -3));
    send_triangle(make_vertex(-32768, -32768, -32768), make_vertex(32767, -32768, -32768),
                  make_vertex(-32768, 32767, -32768));
    send_triangle(make_vertex(32767, -32768, 32767), make_vertex(-32768, 32767, -32768),
                  make_vertex(32767, 32767, -32768));
    send_triangle(make_vertex(0, 0, 0), make_vertex(3, 0, 0), make_vertex(0, 4, 5));
    send_triangle(make_vertex('h5555, 'hAAAA, 'h5555), make_vertex('hAAAA, 'h5555, 'hAAAA),
                  make_vertex(-1, 'h8000, 1));
    wait_results_drained();
  endtask

  task automatic test_random_no_idle();
    set_idling(0, 0);
    send_random_triangles(TRIS_PER_PHASE);
  endtask

  task automatic test_random_sender_idle();
    set_idling(88, 0);
    send_random_triangles(TRIS_PER_PHASE);
  endtask

  task automatic test_random_receiver_stall();
    set_idling(0, 88);
    send_random_triangles(TRIS_PER_PHASE);
    wait_results_drained();
  endtask

  task automatic test_random_both_idle();
    set_idling(8, 8);
    send_random_triangles(TRIS_PER_PHASE);
  endtask

  // The receiver holds off while triangles keep coming, so the output
  // buffer fills and the vertex side has to stall.
  task automatic test_output_backpressure();
    set_idling(0, 0);
    hold_off_request = HOLD_OFF_CYCLES;
    send_random_triangles(5);
    wait_results_drained();
  endtask

  initial begin
    rst          <= 1'b1;
    vertex_valid <= 1'b0;
    vertex       <= '0;
    normal_ready <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_shapes();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_backpressure();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (normal_expected.size() != 0) begin
      normal_faults++;
    end
    if (normal_faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
